// ===== hw/rtl/jgp_pkg.sv =====
// Shared types and constants for the justified glyph placement core.
// Used by jgp_div and justified_glyph_placement_core; depends on nothing.
package jgp_pkg;

  localparam int DIV_W = 16;
  localparam int STEP_IDLE = 30000;
  localparam int STEP_UNIT = 50;
  localparam int SPACE_CAP = 10;
  localparam logic [10:0] X_MAX = 11'h7ff;

  localparam logic [1:0] ALIGN_LEFT = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT = 2'd1;
  localparam logic [1:0] ALIGN_CENTER = 2'd2;
  localparam logic [1:0] ALIGN_JUSTIFY = 2'd3;

  typedef logic [DIV_W-1:0] div_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_SPACE_EXTRA,
    OP_SPACE_STEP,
    OP_CHAR_EXTRA,
    OP_CHAR_STEP
  } op_e;

  typedef struct packed {
    logic start;
    div_t dividend;
    div_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    div_t quot;
    div_t rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/jgp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
module jgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/jgp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line planning step.
// Depends on jgp_pkg for the operand width and request/response structs.
module jgp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jgp_pkg::div_req_t  req_i,
  output jgp_pkg::div_rsp_t  rsp_o
);

  localparam int CNTW = $clog2(jgp_pkg::DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [CNTW-1:0]   cnt_q;
  jgp_pkg::div_t     quo_q;
  jgp_pkg::div_t     rem_q;
  jgp_pkg::div_t     dvs_q;
  logic [jgp_pkg::DIV_W:0] trial;
  logic              fits;

  assign trial = {rem_q, quo_q[jgp_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= jgp_pkg::DIV_W'(trial - {1'b0, dvs_q});
        end else begin
          rem_q <= trial[jgp_pkg::DIV_W-1:0];
        end
        quo_q <= {quo_q[jgp_pkg::DIV_W-2:0], fits};
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(jgp_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/justified_glyph_placement_core.sv =====
// Top level of the justified glyph placement core: line store, planner and emit walk.
// Depends on jgp_pkg, jgp_ram and jgp_div.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | glyph_width, is_space, wide_spacing, last,
//           |                        | start_x, slack, align_mode, justify_enable
//   out     | out_valid_o / out_ready_i | glyph_x, last_glyph
//
// A line of N glyphs loads as N transactions, one transaction per cycle.
// Justified lines then run up to three serial divisions on the
// shared divider; other lines go straight to the walk.
// The walk starts with the first line-store read, then emits one glyph per cycle while the output is not stalled.
// Reset clears all control state; the line store holds no reset value.
// Output stalls hold the walk; input is not taken until the walk ends.
module justified_glyph_placement_core #(
  parameter int LINE_GLYPHS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  glyph_width_i,
  input  logic        is_space_i,
  input  logic        wide_spacing_i,
  input  logic        last_i,
  input  logic [9:0]  start_x_i,
  input  logic [9:0]  slack_i,
  input  logic [1:0]  align_mode_i,
  input  logic        justify_enable_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] glyph_x_o,
  output logic        last_glyph_o
);

  localparam int AW = $clog2(LINE_GLYPHS);
  localparam int CW = $clog2(LINE_GLYPHS + 1);

  jgp_pkg::state_e state_q, state_d;
  jgp_pkg::op_e    op_q, op_d;

  logic [CW-1:0]  cnt_q, spc_q, idx_q;
  logic [9:0]     slack_q;
  logic           just_q;
  logic [10:0]    cursor_q;
  logic [9:0]     se_q, ce_q;
  logic [14:0]    ss_q, cs_q;
  logic [15:0]    sc_q, cc_q;
  jgp_pkg::div_t  rem_q;
  logic           out_valid_q;
  logic [10:0]    x_q;
  logic           lastg_q;

  logic           in_ready;
  logic           in_fire;
  logic           store;
  logic [CW-1:0]  cnt_new, spc_new, chars_new, chars_q, gaps, idx_nx;
  logic           just_new;
  logic           out_free;
  logic           emit_last;
  logic [9:0]     align_add;
  logic [10:0]    cursor_init;
  jgp_pkg::div_t  rest;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [6:0]     mem_wdata, mem_rdata;

  jgp_pkg::div_req_t div_req;
  jgp_pkg::div_rsp_t div_rsp;

  logic [4:0]     g_w;
  logic           g_sp, g_wd;
  logic [15:0]    cnt_sel, cnt_dec, cnt_upd;
  logic [14:0]    step_sel;
  logic           bump;
  logic [9:0]     extra;
  logic [11:0]    add_sum, pos_sum;
  logic [10:0]    cursor_nx;

  jgp_ram #(
    .WIDTH (7),
    .DEPTH (LINE_GLYPHS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  jgp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire   = in_valid_i && in_ready;
  assign store     = cnt_q < CW'(LINE_GLYPHS);
  assign cnt_new   = cnt_q + CW'(store);
  assign spc_new   = spc_q + CW'(store && is_space_i);
  assign chars_new = cnt_new - spc_new;
  assign chars_q   = cnt_q - spc_q;
  assign gaps      = chars_q - CW'(1);
  assign idx_nx    = idx_q + CW'(1);
  assign just_new  = (align_mode_i == jgp_pkg::ALIGN_JUSTIFY) && justify_enable_i;
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = idx_nx == cnt_q;

  always_comb begin
    case (align_mode_i)
      jgp_pkg::ALIGN_RIGHT:  align_add = slack_i;
      jgp_pkg::ALIGN_CENTER: align_add = {1'b0, slack_i[9:1]};
      default:               align_add = '0;
    endcase
  end

  assign cursor_init = 11'(start_x_i) + 11'(align_add);

  assign rest = (spc_q == '0) ? jgp_pkg::div_t'(slack_q) :
                jgp_pkg::div_t'(slack_q) -
                jgp_pkg::div_t'(spc_q) * jgp_pkg::div_t'(jgp_pkg::SPACE_CAP);

  assign g_w      = mem_rdata[4:0];
  assign g_sp     = mem_rdata[5];
  assign g_wd     = mem_rdata[6];
  assign cnt_sel  = g_sp ? sc_q : cc_q;
  assign step_sel = g_sp ? ss_q : cs_q;
  assign cnt_dec  = cnt_sel - 16'(jgp_pkg::STEP_UNIT);
  assign bump     = just_q && cnt_dec[15];
  assign cnt_upd  = cnt_dec[15] ? {1'b0, step_sel} : cnt_dec;
  assign extra    = just_q ? (g_sp ? se_q : ce_q) : '0;
  assign add_sum  = 12'(g_w) + (g_wd ? 12'd2 : 12'd0) + 12'(extra) + 12'(bump);
  assign pos_sum  = 12'(cursor_q) + add_sum;
  assign cursor_nx = (pos_sum > 12'(jgp_pkg::X_MAX)) ? jgp_pkg::X_MAX : pos_sum[10:0];

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      jgp_pkg::ST_LOAD: begin
        if (in_fire && last_i) begin
          state_d = jgp_pkg::ST_READ;
          if (just_new) begin
            if (spc_new != '0) begin
              state_d = jgp_pkg::ST_DIV_GO;
              op_d    = jgp_pkg::OP_SPACE_EXTRA;
            end else if (chars_new > CW'(1)) begin
              state_d = jgp_pkg::ST_DIV_GO;
              op_d    = jgp_pkg::OP_CHAR_EXTRA;
            end
          end
        end
      end
      jgp_pkg::ST_DIV_GO: begin
        state_d = jgp_pkg::ST_DIV_WAIT;
      end
      jgp_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = jgp_pkg::ST_READ;
          case (op_q)
            jgp_pkg::OP_SPACE_EXTRA: begin
              if (div_rsp.quot > jgp_pkg::div_t'(jgp_pkg::SPACE_CAP)) begin
                if (chars_q > CW'(1)) begin
                  state_d = jgp_pkg::ST_DIV_GO;
                  op_d    = jgp_pkg::OP_CHAR_EXTRA;
                end
              end else if (div_rsp.rem != '0) begin
                state_d = jgp_pkg::ST_DIV_GO;
                op_d    = jgp_pkg::OP_SPACE_STEP;
              end
            end
            jgp_pkg::OP_CHAR_EXTRA: begin
              if (div_rsp.rem != '0) begin
                state_d = jgp_pkg::ST_DIV_GO;
                op_d    = jgp_pkg::OP_CHAR_STEP;
              end
            end
            default: begin
              state_d = jgp_pkg::ST_READ;
            end
          endcase
        end
      end
      jgp_pkg::ST_READ: begin
        state_d = jgp_pkg::ST_EMIT;
      end
      jgp_pkg::ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = jgp_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = jgp_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = cnt_q[AW-1:0];
    mem_wdata        = {wide_spacing_i, is_space_i, glyph_width_i};
    mem_re           = 1'b0;
    mem_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      jgp_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        mem_we   = in_valid_i && store;
      end
      jgp_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        case (op_q)
          jgp_pkg::OP_SPACE_EXTRA: begin
            div_req.dividend = jgp_pkg::div_t'(slack_q);
            div_req.divisor  = jgp_pkg::div_t'(spc_q);
          end
          jgp_pkg::OP_SPACE_STEP: begin
            div_req.dividend = jgp_pkg::div_t'(spc_q) *
                               jgp_pkg::div_t'(jgp_pkg::STEP_UNIT);
            div_req.divisor  = rem_q;
          end
          jgp_pkg::OP_CHAR_EXTRA: begin
            div_req.dividend = rest;
            div_req.divisor  = jgp_pkg::div_t'(gaps);
          end
          default: begin
            div_req.dividend = jgp_pkg::div_t'(gaps) *
                               jgp_pkg::div_t'(jgp_pkg::STEP_UNIT);
            div_req.divisor  = rem_q;
          end
        endcase
      end
      jgp_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      jgp_pkg::ST_EMIT: begin
        if (out_free && !emit_last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_nx[AW-1:0];
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jgp_pkg::ST_LOAD;
      op_q        <= jgp_pkg::OP_SPACE_EXTRA;
      cnt_q       <= '0;
      spc_q       <= '0;
      idx_q       <= '0;
      slack_q     <= '0;
      just_q      <= 1'b0;
      cursor_q    <= '0;
      se_q        <= '0;
      ce_q        <= '0;
      ss_q        <= 15'(jgp_pkg::STEP_IDLE);
      cs_q        <= 15'(jgp_pkg::STEP_IDLE);
      sc_q        <= 16'(jgp_pkg::STEP_IDLE);
      cc_q        <= 16'(jgp_pkg::STEP_IDLE);
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      lastg_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;

      if (in_fire) begin
        cnt_q <= cnt_new;
        spc_q <= spc_new;
        if (last_i) begin
          slack_q  <= slack_i;
          just_q   <= just_new;
          cursor_q <= cursor_init;
          se_q     <= '0;
          ce_q     <= '0;
          ss_q     <= 15'(jgp_pkg::STEP_IDLE);
          cs_q     <= 15'(jgp_pkg::STEP_IDLE);
        end
      end

      if (state_q == jgp_pkg::ST_DIV_WAIT && div_rsp.done) begin
        case (op_q)
          jgp_pkg::OP_SPACE_EXTRA: begin
            rem_q <= div_rsp.rem;
            if (div_rsp.quot > jgp_pkg::div_t'(jgp_pkg::SPACE_CAP)) begin
              se_q <= 10'(jgp_pkg::SPACE_CAP);
              ss_q <= 15'(jgp_pkg::STEP_IDLE);
            end else begin
              se_q <= div_rsp.quot[9:0];
            end
          end
          jgp_pkg::OP_SPACE_STEP: begin
            ss_q <= div_rsp.quot[14:0];
          end
          jgp_pkg::OP_CHAR_EXTRA: begin
            rem_q <= div_rsp.rem;
            ce_q  <= div_rsp.quot[9:0];
          end
          default: begin
            cs_q <= div_rsp.quot[14:0];
          end
        endcase
      end

      if (state_q == jgp_pkg::ST_READ) begin
        sc_q  <= {1'b0, ss_q};
        cc_q  <= {1'b0, cs_q};
        idx_q <= '0;
      end

      if (state_q == jgp_pkg::ST_EMIT && out_free) begin
        x_q      <= cursor_q;
        lastg_q  <= emit_last;
        cursor_q <= cursor_nx;
        idx_q    <= idx_nx;
        if (just_q && g_sp) begin
          sc_q <= cnt_upd;
        end
        if (just_q && !g_sp) begin
          cc_q <= cnt_upd;
        end
        if (emit_last) begin
          cnt_q <= '0;
          spc_q <= '0;
        end
      end

      if (state_q == jgp_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;
  assign glyph_x_o    = x_q;
  assign last_glyph_o = lastg_q;

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jgp_pkg::ST_EMIT) |-> (idx_q < cnt_q))
    else $error("emit index beyond stored glyph count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LINE_GLYPHS))
    else $error("glyph count exceeds line store depth");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == jgp_pkg::ST_DIV_WAIT))
    else $error("divider finished outside of planning wait");

  a_space_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jgp_pkg::ST_READ) |-> (se_q <= 10'(jgp_pkg::SPACE_CAP)))
    else $error("space extra above cap at start of walk");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jgp_pkg::ST_EMIT && out_free && emit_last) |=>
      (out_valid_q && lastg_q && state_q == jgp_pkg::ST_LOAD && cnt_q == '0))
    else $error("line end did not flag last glyph and return to load");

endmodule
